FILE: rtl/disk_seek_scheduler_assert.svh
// Assertion helpers for the scheduler datapath
`ifndef DISK_SEEK_SCHEDULER_ASSERT_SVH
`define DISK_SEEK_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define DSS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define DSS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/dss_pkg.sv
package dss_pkg;

   // Policy codes; unused codes fall back to FCFS
   localparam logic [2:0] POL_FCFS  = 3'd0;
   localparam logic [2:0] POL_SSTF  = 3'd1;
   localparam logic [2:0] POL_SCAN  = 3'd2;
   localparam logic [2:0] POL_CSCAN = 3'd3;
   localparam logic [2:0] POL_LOOK  = 3'd4;
   localparam logic [2:0] POL_CLOOK = 3'd5;

   // Register indexes
   localparam logic [1:0] REG_POLICY    = 2'd0;
   localparam logic [1:0] REG_DIRECTION = 2'd1;
   localparam logic [1:0] REG_START     = 2'd2;
   localparam logic [1:0] REG_MAXCYL    = 2'd3;

   // Scan selection criteria
   localparam logic [1:0] CRIT_FIRST    = 2'd0;
   localparam logic [1:0] CRIT_MIN_VAL  = 2'd1;
   localparam logic [1:0] CRIT_MAX_VAL  = 2'd2;
   localparam logic [1:0] CRIT_MIN_DIST = 2'd3;

   // Scan ranges relative to the batch start head
   localparam logic [2:0] RNG_ALL = 3'd0;
   localparam logic [2:0] RNG_GE  = 3'd1;
   localparam logic [2:0] RNG_LE  = 3'd2;
   localparam logic [2:0] RNG_GT  = 3'd3;
   localparam logic [2:0] RNG_LT  = 3'd4;

   localparam int          SUM_W         = 22;
   localparam logic [21:0] SUM_MAX       = 22'h3FFFFF;
   localparam logic [31:0] MAX_CYL_RESET = 32'd65535;

   typedef struct packed {
      logic       load;
      logic       batch_init;
      logic       scan_clear;
      logic       scan_run;
      logic       commit_req;
      logic       commit_stop;
      logic       stop_cyl_max;
      logic       stop_jump;
      logic       flush;
      logic [1:0] crit;
      logic [2:0] rng;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic found;
   } status_type;

endpackage

FILE: rtl/dss_ctrl.sv
module dss_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               req_last_request,
   input  logic [2:0]         policy,
   input  logic               direction,
   input  dss_pkg::status_type status,
   output dss_pkg::cmd_type    cmd,
   output logic               busy
);
   import dss_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SETUP = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_PICK  = 3'd3;
   localparam logic [2:0] S_STOP1 = 3'd4;
   localparam logic [2:0] S_STOP2 = 3'd5;
   localparam logic [2:0] S_FLUSH = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       phase_b_ff, phase_b_in;
   logic       is_sweep, is_circ, has_stop, has_b;

   // Decode the policy into sweep shape
   assign is_sweep = (policy == POL_SCAN) || (policy == POL_LOOK);
   assign is_circ  = (policy == POL_CSCAN) || (policy == POL_CLOOK);
   assign has_stop = (policy == POL_SCAN) || (policy == POL_CSCAN);
   assign has_b    = is_sweep || is_circ;

   // Pick criterion and range for the current phase, then the next state and commands
   always_comb begin
      cmd      = '0;
      cmd.crit = CRIT_FIRST;
      cmd.rng  = RNG_ALL;
      if (policy == POL_SSTF) begin
         cmd.crit = CRIT_MIN_DIST;
      end else if (is_circ) begin
         cmd.crit = CRIT_MIN_VAL;
         cmd.rng  = phase_b_ff ? RNG_LT : RNG_GE;
      end else if (is_sweep) begin
         if (direction ^ phase_b_ff) begin
            cmd.crit = CRIT_MIN_VAL;
            cmd.rng  = phase_b_ff ? RNG_GT : RNG_GE;
         end else begin
            cmd.crit = CRIT_MAX_VAL;
            cmd.rng  = phase_b_ff ? RNG_LT : RNG_LE;
         end
      end

      state_in   = state_ff;
      phase_b_in = phase_b_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (req_last_request) begin
                  state_in = S_SETUP;
               end
            end
         end
         S_SETUP: begin
            cmd.batch_init = 1'b1;
            cmd.scan_clear = 1'b1;
            phase_b_in     = 1'b0;
            state_in       = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (status.scan_done) begin
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            if (status.found) begin
               cmd.commit_req = 1'b1;
               cmd.scan_clear = 1'b1;
               state_in       = S_SCAN;
            end else if (!phase_b_ff && has_stop) begin
               state_in = S_STOP1;
            end else if (!phase_b_ff && has_b) begin
               cmd.scan_clear = 1'b1;
               phase_b_in     = 1'b1;
               state_in       = S_SCAN;
            end else begin
               state_in = S_FLUSH;
            end
         end
         S_STOP1: begin
            cmd.commit_stop  = 1'b1;
            cmd.stop_cyl_max = (policy == POL_CSCAN) || direction;
            if (policy == POL_CSCAN) begin
               state_in = S_STOP2;
            end else begin
               cmd.scan_clear = 1'b1;
               phase_b_in     = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_STOP2: begin
            cmd.commit_stop = 1'b1;
            cmd.stop_jump   = 1'b1;
            cmd.scan_clear  = 1'b1;
            phase_b_in      = 1'b1;
            state_in        = S_SCAN;
         end
         S_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   // Advance the sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         phase_b_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         phase_b_ff <= phase_b_in;
      end
   end

endmodule

FILE: rtl/dss_datapath.sv
`include "disk_seek_scheduler_assert.svh"

module dss_datapath #(
   parameter int MAX_REQUESTS = 32,
   parameter int CYL_BITS     = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dss_pkg::cmd_type          cmd,
   output dss_pkg::status_type       status,
   input  logic [CYL_BITS-1:0]       req_request_cylinder,
   input  logic [CYL_BITS-1:0]       start_head,
   input  logic [CYL_BITS-1:0]       cyl_limit,
   output logic                      rsp_strobe,
   output logic [CYL_BITS-1:0]       rsp_visit_cylinder,
   output logic [CYL_BITS-1:0]       rsp_step_distance,
   output logic [dss_pkg::SUM_W-1:0] rsp_head_travel,
   output logic                      rsp_is_end_stop,
   output logic                      rsp_last_visit
);
   import dss_pkg::*;

   localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
   localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int ADD_W = ((CYL_BITS > SUM_W) ? CYL_BITS : SUM_W) + 1;

   function automatic logic [CYL_BITS-1:0] absdiff(input logic [CYL_BITS-1:0] a,
                                                   input logic [CYL_BITS-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   logic [CYL_BITS-1:0]     mem [MAX_REQUESTS];
   logic [CNT_W-1:0]        count_ff;
   logic [MAX_REQUESTS-1:0] served_ff;
   logic [CNT_W-1:0]        scan_addr_ff;
   logic                    rd_vld_ff;
   logic [IDX_W-1:0]        rd_idx_ff;
   logic [CYL_BITS-1:0]     rd_data_ff;
   logic                    found_ff;
   logic [CYL_BITS-1:0]     best_val_ff;
   logic [CYL_BITS-1:0]     best_dist_ff;
   logic [IDX_W-1:0]        best_idx_ff;
   logic [CYL_BITS-1:0]     head_ff;
   logic [SUM_W-1:0]        sum_ff;
   logic                    pend_vld_ff;
   logic [CYL_BITS-1:0]     pend_cyl_ff;
   logic [CYL_BITS-1:0]     pend_dist_ff;
   logic [SUM_W-1:0]        pend_sum_ff;
   logic                    pend_stop_ff;
   logic                    rsp_strobe_ff;
   logic [CYL_BITS-1:0]     rsp_cyl_ff;
   logic [CYL_BITS-1:0]     rsp_dist_ff;
   logic [SUM_W-1:0]        rsp_sum_ff;
   logic                    rsp_stop_ff;
   logic                    rsp_last_ff;

   logic                    store_ok, rd_issue, in_rng, better, take;
   logic [CYL_BITS-1:0]     cand_dist;
   logic                    commit;
   logic [CYL_BITS-1:0]     commit_cyl, commit_dist;
   logic [ADD_W-1:0]        sum_add;
   logic [SUM_W-1:0]        sum_in;
   logic                    batch_closed;

   assign store_ok = cmd.load && (count_ff < CNT_W'(MAX_REQUESTS));
   assign rd_issue = cmd.scan_run && (scan_addr_ff != count_ff);

   assign status.scan_done = (scan_addr_ff == count_ff) && !rd_vld_ff;
   assign status.found     = found_ff;

   // Store the request beat and read one entry per scan cycle
   always_ff @(posedge clock) begin
      if (store_ok) begin
         mem[count_ff[IDX_W-1:0]] <= req_request_cylinder;
      end
      if (rd_issue) begin
         rd_data_ff <= mem[scan_addr_ff[IDX_W-1:0]];
      end
   end

   // Compare the entry just read against the best so far
   always_comb begin
      cand_dist = absdiff(rd_data_ff, head_ff);
      case (cmd.rng)
         RNG_ALL: in_rng = 1'b1;
         RNG_GE:  in_rng = rd_data_ff >= start_head;
         RNG_LE:  in_rng = rd_data_ff <= start_head;
         RNG_GT:  in_rng = rd_data_ff > start_head;
         RNG_LT:  in_rng = rd_data_ff < start_head;
         default: in_rng = 1'b0;
      endcase
      case (cmd.crit)
         CRIT_FIRST:    better = !found_ff;
         CRIT_MIN_VAL:  better = !found_ff || (rd_data_ff < best_val_ff);
         CRIT_MAX_VAL:  better = !found_ff || (rd_data_ff > best_val_ff);
         CRIT_MIN_DIST: better = !found_ff || (cand_dist < best_dist_ff);
         default:       better = 1'b0;
      endcase
      take = rd_vld_ff && !served_ff[rd_idx_ff] && in_rng && better;
   end

   // Build the visit: a request, an end stop, or the jump back to zero
   always_comb begin
      commit = cmd.commit_req || cmd.commit_stop;
      if (cmd.commit_req) begin
         commit_cyl = best_val_ff;
      end else if (cmd.stop_cyl_max) begin
         commit_cyl = cyl_limit;
      end else begin
         commit_cyl = '0;
      end
      commit_dist = cmd.stop_jump ? cyl_limit : absdiff(commit_cyl, head_ff);
      sum_add     = ADD_W'(sum_ff) + ADD_W'(commit_dist);
      sum_in      = (sum_add > ADD_W'(SUM_MAX)) ? SUM_MAX : sum_add[SUM_W-1:0];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         served_ff     <= '0;
         scan_addr_ff  <= '0;
         rd_vld_ff     <= 1'b0;
         found_ff      <= 1'b0;
         pend_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (cmd.flush) begin
            count_ff <= '0;
         end else if (store_ok) begin
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.batch_init) begin
            served_ff <= '0;
         end else if (cmd.commit_req) begin
            served_ff[best_idx_ff] <= 1'b1;
         end
         if (cmd.scan_clear) begin
            scan_addr_ff <= '0;
         end else if (rd_issue) begin
            scan_addr_ff <= scan_addr_ff + 1'b1;
         end
         rd_vld_ff <= rd_issue;
         if (cmd.scan_clear) begin
            found_ff <= 1'b0;
         end else if (take) begin
            found_ff <= 1'b1;
         end
         if (cmd.batch_init || cmd.flush) begin
            pend_vld_ff <= 1'b0;
         end else if (commit) begin
            pend_vld_ff <= 1'b1;
         end
         rsp_strobe_ff <= (commit && pend_vld_ff) || cmd.flush;
      end
   end

   // Payload: scan bests, head, running sum, held visit and result beat
   always_ff @(posedge clock) begin
      rd_idx_ff <= scan_addr_ff[IDX_W-1:0];
      if (take) begin
         best_val_ff  <= rd_data_ff;
         best_dist_ff <= cand_dist;
         best_idx_ff  <= rd_idx_ff;
      end
      if (cmd.batch_init) begin
         head_ff <= start_head;
         sum_ff  <= '0;
      end else if (commit) begin
         head_ff <= commit_cyl;
         sum_ff  <= sum_in;
      end
      if (commit) begin
         pend_cyl_ff  <= commit_cyl;
         pend_dist_ff <= commit_dist;
         pend_sum_ff  <= sum_in;
         pend_stop_ff <= cmd.commit_stop;
      end
      rsp_cyl_ff  <= pend_cyl_ff;
      rsp_dist_ff <= pend_dist_ff;
      rsp_sum_ff  <= pend_sum_ff;
      rsp_stop_ff <= pend_stop_ff;
      rsp_last_ff <= cmd.flush;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_visit_cylinder = rsp_cyl_ff;
   assign rsp_step_distance  = rsp_dist_ff;
   assign rsp_head_travel    = rsp_sum_ff;
   assign rsp_is_end_stop    = rsp_stop_ff;
   assign rsp_last_visit     = rsp_last_ff;

   // Batch is closed once the last beat is out and the store is empty
   assign batch_closed = !pend_vld_ff && rsp_strobe_ff && rsp_last_ff && (count_ff == '0);

   `DSS_ASSERT_IMP(a_commit_found, clock, reset, cmd.commit_req, found_ff, "commit without a found entry")
   `DSS_ASSERT_IMP(a_flush_pending, clock, reset, cmd.flush, pend_vld_ff, "batch ended with no visit held")
   `DSS_ASSERT_NXT(a_flush_clears, clock, reset, cmd.flush, batch_closed, "batch left open")

endmodule

FILE: rtl/disk_seek_scheduler.sv
// Disk head scheduler.
// Requests arrive on req_request_cylinder, one per cycle, taken when start is
// high and busy is low. Up to MAX_REQUESTS are stored; later ones are dropped.
// The beat with req_last_request set starts a scheduling pass under the policy
// in the CSR file (FCFS, SSTF, SCAN, C-SCAN, LOOK, C-LOOK), from start_head.
// busy stays high for the whole pass; no request is taken then.
// Each visit comes out as one rsp_strobe beat with cylinder, step distance,
// saturating running total, end-stop flag, and rsp_last_visit on the last one.
// Each visit is found by one walk over the n stored requests through the
// single read port of the request memory. A pass takes one walk per visit
// plus one empty walk per sweep phase (one for FCFS and SSTF, two for the
// others), with a sequencer state for each end stop, plus setup and flush
// states. Results are held one visit back, so the first beat leaves when
// the second visit is committed, or at the flush for a lone visit.
// The receiver cannot stall; every beat is valid for exactly one cycle.
// Reset clears the request count, the sequencer and the CSRs to their defaults.
// Write the CSRs only while busy is low.
module disk_seek_scheduler #(
   parameter int MAX_REQUESTS = 32,
   parameter int CYL_BITS     = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [CYL_BITS-1:0]       req_request_cylinder,
   input  logic                      req_last_request,
   output logic                      rsp_strobe,
   output logic [CYL_BITS-1:0]       rsp_visit_cylinder,
   output logic [CYL_BITS-1:0]       rsp_step_distance,
   output logic [dss_pkg::SUM_W-1:0] rsp_head_travel,
   output logic                      rsp_is_end_stop,
   output logic                      rsp_last_visit,
   input  logic                      csr_wr_en,
   input  logic [1:0]                csr_index,
   input  logic [CYL_BITS-1:0]       csr_wdata
);
   import dss_pkg::*;

   logic [2:0]          policy_ff;
   logic                direction_ff;
   logic [CYL_BITS-1:0] start_head_ff;
   logic [CYL_BITS-1:0] max_cyl_ff;
   cmd_type             cmd;
   status_type          status;

   // CSR file
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff     <= POL_FCFS;
         direction_ff  <= 1'b1;
         start_head_ff <= '0;
         max_cyl_ff    <= CYL_BITS'(MAX_CYL_RESET);
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_POLICY:    policy_ff     <= csr_wdata[2:0];
            REG_DIRECTION: direction_ff  <= csr_wdata[0];
            REG_START:     start_head_ff <= csr_wdata;
            REG_MAXCYL:    max_cyl_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   dss_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_last_request (req_last_request),
      .policy           (policy_ff),
      .direction        (direction_ff),
      .status           (status),
      .cmd              (cmd),
      .busy             (busy)
   );

   dss_datapath #(
      .MAX_REQUESTS (MAX_REQUESTS),
      .CYL_BITS     (CYL_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_request_cylinder (req_request_cylinder),
      .start_head           (start_head_ff),
      .cyl_limit            (max_cyl_ff),
      .rsp_strobe           (rsp_strobe),
      .rsp_visit_cylinder   (rsp_visit_cylinder),
      .rsp_step_distance    (rsp_step_distance),
      .rsp_head_travel      (rsp_head_travel),
      .rsp_is_end_stop      (rsp_is_end_stop),
      .rsp_last_visit       (rsp_last_visit)
   );

endmodule

FILE: sim/disk_seek_checker.sv
module disk_seek_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [15:0] req_request_cylinder,
   input  logic        req_last_request,
   input  logic        rsp_strobe,
   input  logic [15:0] rsp_visit_cylinder,
   input  logic [15:0] rsp_step_distance,
   input  logic [21:0] rsp_head_travel,
   input  logic        rsp_is_end_stop,
   input  logic        rsp_last_visit,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending_visits
);
   timeunit 1ns;
   timeprecision 1ps;
   import dss_pkg::*;

   typedef struct packed {
      logic [15:0] cyl;
      logic [15:0] span;
      logic [21:0] total;
      logic        stop;
      logic        last;
   } visit_type;

   localparam int DEPTH = 32;

   visit_type   visit_queue[$];
   logic [2:0]  policy;
   logic        sweep_up;
   logic [15:0] head_start;
   logic [15:0] cyl_limit;
   logic [15:0] stored[DEPTH];
   int          stored_count;
   logic [15:0] head;
   logic [21:0] moved;

   assign pending_visits = visit_queue.size();

   // Move the head and queue one visit
   function automatic void push_visit(logic [15:0] cyl, logic [15:0] span, logic stop);
      visit_type v;
      logic [22:0] s;
      s = moved + span;
      moved = (s > SUM_MAX) ? SUM_MAX : s[21:0];
      head = cyl;
      v.cyl = cyl;
      v.span = span;
      v.total = moved;
      v.stop = stop;
      v.last = 1'b0;
      visit_queue.push_back(v);
   endfunction

   function automatic void seek_to(logic [15:0] cyl, logic stop);
      push_visit(cyl, (cyl > head) ? cyl - head : head - cyl, stop);
   endfunction

   // Work out the visit order of the stored batch
   function automatic void plan_batch();
      logic [15:0] srt[DEPTH];
      logic [15:0] tmp;
      logic        done[DEPTH];
      int          n, start_size, best;
      logic [15:0] bd, d;
      n = stored_count;
      start_size = visit_queue.size();
      head = head_start;
      moved = '0;
      for (int i = 0; i < n; i++) begin
         srt[i] = stored[i];
         done[i] = 1'b0;
      end
      for (int i = 1; i < n; i++)
         for (int j = i; j > 0 && srt[j-1] > srt[j]; j--) begin
            tmp = srt[j]; srt[j] = srt[j-1]; srt[j-1] = tmp;
         end
      case (policy)
         POL_SSTF: begin
            for (int i = 0; i < n; i++) begin
               best = -1;
               bd = '0;
               for (int j = 0; j < n; j++) begin
                  if (!done[j]) begin
                     d = (stored[j] > head) ? stored[j] - head : head - stored[j];
                     if (best < 0 || d < bd) begin
                        best = j;
                        bd = d;
                     end
                  end
               end
               done[best] = 1'b1;
               seek_to(stored[best], 1'b0);
            end
         end
         POL_SCAN, POL_LOOK: begin
            if (sweep_up) begin
               for (int i = 0; i < n; i++) if (srt[i] >= head_start) seek_to(srt[i], 1'b0);
               if (policy == POL_SCAN) seek_to(cyl_limit, 1'b1);
               for (int i = n - 1; i >= 0; i--) if (srt[i] < head_start) seek_to(srt[i], 1'b0);
            end else begin
               for (int i = n - 1; i >= 0; i--) if (srt[i] <= head_start) seek_to(srt[i], 1'b0);
               if (policy == POL_SCAN) seek_to(16'd0, 1'b1);
               for (int i = 0; i < n; i++) if (srt[i] > head_start) seek_to(srt[i], 1'b0);
            end
         end
         POL_CSCAN: begin
            for (int i = 0; i < n; i++) if (srt[i] >= head_start) seek_to(srt[i], 1'b0);
            seek_to(cyl_limit, 1'b1);
            push_visit(16'd0, cyl_limit, 1'b1);
            for (int i = 0; i < n; i++) if (srt[i] < head_start) seek_to(srt[i], 1'b0);
         end
         POL_CLOOK: begin
            for (int i = 0; i < n; i++) if (srt[i] >= head_start) seek_to(srt[i], 1'b0);
            for (int i = 0; i < n; i++) if (srt[i] < head_start) seek_to(srt[i], 1'b0);
         end
         default: begin
            for (int i = 0; i < n; i++) seek_to(stored[i], 1'b0);
         end
      endcase
      if (visit_queue.size() > start_size) visit_queue[$].last = 1'b1;
      stored_count = 0;
   endfunction

   // Track registers, load requests, check visits
   always @(posedge clock) begin
      visit_type exp_v;
      if (reset) begin
         policy <= POL_FCFS;
         sweep_up <= 1'b1;
         head_start <= '0;
         cyl_limit <= 16'hFFFF;
         stored_count = 0;
         fail_count = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_POLICY:    policy <= csr_wdata[2:0];
               REG_DIRECTION: sweep_up <= csr_wdata[0];
               REG_START:     head_start <= csr_wdata;
               REG_MAXCYL:    cyl_limit <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_strobe) begin
            if (visit_queue.size() == 0) begin
               $error("unexpected visit beat cyl=%0d", rsp_visit_cylinder);
               fail_count++;
            end else begin
               exp_v = visit_queue.pop_front();
               if (rsp_visit_cylinder !== exp_v.cyl) begin
                  $error("visit_cylinder exp %0d got %0d", exp_v.cyl, rsp_visit_cylinder);
                  fail_count++;
               end
               if (rsp_step_distance !== exp_v.span) begin
                  $error("step_distance exp %0d got %0d", exp_v.span, rsp_step_distance);
                  fail_count++;
               end
               if (rsp_head_travel !== exp_v.total) begin
                  $error("head_travel exp %0d got %0d", exp_v.total, rsp_head_travel);
                  fail_count++;
               end
               if (rsp_is_end_stop !== exp_v.stop) begin
                  $error("is_end_stop exp %0d got %0d", exp_v.stop, rsp_is_end_stop);
                  fail_count++;
               end
               if (rsp_last_visit !== exp_v.last) begin
                  $error("last_visit exp %0d got %0d", exp_v.last, rsp_last_visit);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            if (stored_count < DEPTH) begin
               stored[stored_count] = req_request_cylinder;
               stored_count++;
            end
            if (req_last_request) plan_batch();
         end
      end
   end
endmodule

FILE: sim/disk_seek_scheduler_tb.sv
module disk_seek_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dss_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [15:0] req_request_cylinder = '0;
   logic        req_last_request = 1'b0;
   logic        rsp_strobe;
   logic [15:0] rsp_visit_cylinder;
   logic [15:0] rsp_step_distance;
   logic [21:0] rsp_head_travel;
   logic        rsp_is_end_stop;
   logic        rsp_last_visit;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;
   int          fail_count;
   int          pending_visits;
   int          beats_sent;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   disk_seek_scheduler dut (.*);
   disk_seek_checker chk (.*);

   // Write one register while the block is idle
   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_wr_en <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Hold start until one request beat is taken
   task automatic send_request(logic [15:0] cyl, logic last);
      req_request_cylinder <= cyl;
      req_last_request <= last;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      beats_sent++;
   endtask

   task automatic drop_start();
      start <= 1'b0;
      @(negedge clock);
   endtask

   // Wait out the scheduling pass and any trailing cycles
   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (busy || pending_visits != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   function automatic logic [15:0] pick_cyl(logic [15:0] hd, logic [15:0] mx);
      case ($urandom_range(0, 7))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return hd;
         3: return mx;
         4: return hd + 16'($urandom_range(0, 40)) - 16'd20;
         default: return 16'($urandom());
      endcase
   endfunction

   // Send a batch of n requests, sometimes pausing between bursts
   task automatic send_batch(int n, logic [15:0] hd, logic [15:0] mx);
      int burst;
      burst = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
         send_request(pick_cyl(hd, mx), i == n - 1);
         if (--burst == 0) begin
            burst = $urandom_range(1, 8);
            if ($urandom_range(0, 1)) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 5)) @(negedge clock);
            end
         end
      end
      drop_start();
   endtask

   initial begin
      logic [15:0] hd, mx;
      int n;
      beats_sent = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset settings, extremes, every policy
      send_request(16'hFFFF, 1'b0);
      send_request(16'd0, 1'b0);
      send_request(16'd5, 1'b1);
      drain();
      write_reg(REG_START, 16'd100);
      write_reg(REG_MAXCYL, 16'd200);
      for (int p = 0; p < 8; p++) begin
         write_reg(REG_POLICY, 16'(p));
         write_reg(REG_DIRECTION, 16'(p[0]));
         send_request(16'd90, 1'b0);
         send_request(16'd110, 1'b0);
         send_request(16'd100, 1'b1);
         drain();
      end
      // Lone request, and an overfull batch
      write_reg(REG_POLICY, 16'(POL_CLOOK));
      send_request(16'd50, 1'b1);
      drain();
      write_reg(REG_POLICY, 16'(POL_FCFS));
      for (int i = 0; i < 34; i++) send_request(16'hFFFF - 16'(i), i == 33);
      drain();
      // Full batches at the cylinder extremes: C-SCAN from the top, then SSTF from zero
      write_reg(REG_POLICY, 16'(POL_CSCAN));
      write_reg(REG_START, 16'hFFFF);
      write_reg(REG_MAXCYL, 16'hFFFF);
      for (int i = 0; i < 32; i++) send_request(16'hFFFF - 16'(i & 1), i == 31);
      drain();
      write_reg(REG_POLICY, 16'(POL_SSTF));
      write_reg(REG_START, 16'd0);
      for (int i = 0; i < 32; i++) send_request((i & 1) ? 16'hFFFF : 16'd0, i == 31);
      drain();

      // Random batches under random settings
      while (beats_sent < 380) begin
         if ($urandom_range(0, 3) == 0)
            hd = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd0;
         else
            hd = 16'($urandom());
         if ($urandom_range(0, 3) == 0)
            mx = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd0;
         else
            mx = 16'($urandom());
         write_reg(REG_POLICY, 16'($urandom_range(0, 7)));
         write_reg(REG_DIRECTION, 16'($urandom_range(0, 1)));
         write_reg(REG_START, hd);
         write_reg(REG_MAXCYL, mx);
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 12);
         send_batch(n, hd, mx);
         drain();
      end

      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end
endmodule
